FILE: rtl/sce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI EEPROM command engine package
// Shared types, register map and command codes for the SPI EEPROM engine.
// ----------------------------------------------------------------------------
package sce_pkg;

    localparam int MEM_BYTES = 131072;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int ADDR_W    = 17;
    localparam int PADDR_W   = 5;

    // command codes
    localparam logic [7:0] CMD_WRSR  = 8'h01;
    localparam logic [7:0] CMD_WRITE = 8'h02;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_WRDI  = 8'h04;
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_WREN  = 8'h06;

    localparam logic [7:0] ST_KEEP_MASK = 8'h8E;
    localparam logic [7:0] BYTE_FF      = 8'hFF;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_ADDRESS_BYTES = 3'd0;
    localparam logic [2:0] REG_ADDRESS_MASK  = 3'd1;
    localparam logic [2:0] REG_PAGE_WRAP     = 3'd2;
    localparam logic [2:0] REG_HALF_START    = 3'd3;
    localparam logic [2:0] REG_QUARTER_START = 3'd4;

    localparam logic [1:0]        RST_ADDRESS_BYTES = 2'd2;
    localparam logic [ADDR_W-1:0] RST_ADDRESS_MASK  = ADDR_W'(8191);
    localparam logic [7:0]        RST_PAGE_WRAP     = 8'd31;
    localparam logic [ADDR_W-1:0] RST_HALF_START    = ADDR_W'(4096);
    localparam logic [ADDR_W-1:0] RST_QUARTER_START = ADDR_W'(6144);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       keep_selected;
    } t_in;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       store_dirty;
    } t_out;

    typedef struct packed {
        logic [1:0]        address_bytes;
        logic [ADDR_W-1:0] address_mask;
        logic [7:0]        page_wrap;
        logic [ADDR_W-1:0] half_start;
        logic [ADDR_W-1:0] quarter_start;
    } t_cfg;

endpackage
`default_nettype wire

FILE: rtl/sce_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI EEPROM configuration registers
// APB-style register file holding address and protection geometry.
// ----------------------------------------------------------------------------
module sce_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sce_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output sce_pkg::t_cfg                    o_cfg
);
    import sce_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.address_bytes <= RST_ADDRESS_BYTES;
            r_cfg.address_mask  <= RST_ADDRESS_MASK;
            r_cfg.page_wrap     <= RST_PAGE_WRAP;
            r_cfg.half_start    <= RST_HALF_START;
            r_cfg.quarter_start <= RST_QUARTER_START;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ADDRESS_BYTES: r_cfg.address_bytes <= pwdata[1:0];
                REG_ADDRESS_MASK:  r_cfg.address_mask  <= pwdata[ADDR_W-1:0];
                REG_PAGE_WRAP:     r_cfg.page_wrap     <= pwdata[7:0];
                REG_HALF_START:    r_cfg.half_start    <= pwdata[ADDR_W-1:0];
                REG_QUARTER_START: r_cfg.quarter_start <= pwdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ADDRESS_BYTES: prdata = {30'b0, r_cfg.address_bytes};
            REG_ADDRESS_MASK:  prdata = {{(32-ADDR_W){1'b0}}, r_cfg.address_mask};
            REG_PAGE_WRAP:     prdata = {24'b0, r_cfg.page_wrap};
            REG_HALF_START:    prdata = {{(32-ADDR_W){1'b0}}, r_cfg.half_start};
            REG_QUARTER_START: prdata = {{(32-ADDR_W){1'b0}}, r_cfg.quarter_start};
            default:           prdata = 32'b0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/spi_eeprom_command_engine.sv
`default_nettype none
// Path: an accepted request is registered in the result stage (r_s1_*) and
// then in the output register (r_o_*), from which its result is taken.
// Throughput: one request per cycle; the single memory port does one read
// and one write-back slot per request, so nothing stalls but the output side.
// Reset: synchronous, active low; clears control state and configuration.
// The data array is not cleared and holds no valid bits.
// ----------------------------------------------------------------------------
// SPI EEPROM command engine
// Byte-level 25xx-style serial EEPROM slave with a synchronous, registered-read array.
// ----------------------------------------------------------------------------
module spi_eeprom_command_engine (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire sce_pkg::t_in                i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output sce_pkg::t_out                    o_out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sce_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import sce_pkg::*;

    typedef enum logic [1:0] {
        OUT_KEEP = 2'd0,
        OUT_SET  = 2'd1,
        OUT_MEM  = 2'd2
    } t_out_kind;

    localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W+1)'(MEM_BYTES);

    t_cfg cfg;

    sce_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // protocol state
    logic              r_selected, n_selected;
    logic [7:0]        r_command, n_command;
    logic [1:0]        r_pos, n_pos;
    logic [ADDR_W-1:0] r_address, n_address;
    logic [7:0]        r_status, n_status;
    logic              r_dirty, n_dirty;

    // array
    logic [7:0]        r_mem [MEM_BYTES];
    logic [7:0]        r_rd_data;

    // result stage and output register
    logic              r_s1_valid;
    t_out_kind         r_s1_kind;
    logic [7:0]        r_s1_val;
    logic              r_s1_dirty;
    logic [7:0]        r_out_byte;
    logic              r_o_valid;
    t_out              r_o_data;

    logic              in_accept, s1_move;
    t_out_kind         kind;
    logic [7:0]        set_val;
    logic              mem_we;
    logic [7:0]        v;
    logic [ADDR_W-1:0] addr_inc, addr_base, page17;
    logic [1:0]        n_bytes, eff_pos, pos_adv, mode;
    logic              in_range, refused;
    logic [7:0]        s1_byte;

    assign v         = i_in_data.data_byte;
    assign s1_move   = r_s1_valid & (~r_o_valid | ~i_out_stall);
    assign o_in_stall = r_s1_valid & ~s1_move;
    assign in_accept = i_in_valid & ~o_in_stall;

    assign addr_inc  = r_address + ADDR_W'(1);
    assign page17    = {{(ADDR_W-8){1'b0}}, cfg.page_wrap};
    assign in_range  = {1'b0, r_address} < MEM_LIMIT;
    assign pos_adv   = (r_pos == 2'd3) ? 2'd3 : r_pos + 2'd1;
    assign mode      = r_status[3:2];
    assign refused   = (mode == 2'd3)
                    || (mode == 2'd1 && r_address >= cfg.quarter_start)
                    || (mode == 2'd2 && r_address >= cfg.half_start);

    // address byte capture: a short address starts part way through the three bytes
    assign n_bytes   = (cfg.address_bytes == 2'd0) ? 2'd1 : cfg.address_bytes;
    assign eff_pos   = (r_pos == 2'd0) ? 2'd3 - n_bytes : r_pos;
    assign addr_base = (r_pos == 2'd0) ? '0 : r_address;

    always_comb begin
        n_selected = i_in_data.keep_selected;
        n_command  = r_command;
        n_pos      = r_pos;
        n_address  = r_address;
        n_status   = r_status;
        n_dirty    = r_dirty;
        kind       = OUT_KEEP;
        set_val    = r_status;
        mem_we     = 1'b0;
        if (!r_selected) begin
            n_command = v;
            n_pos     = 2'd0;
        end else begin
            unique case (r_command)
                CMD_WREN: begin
                    if (r_pos == 2'd0) n_status = r_status | 8'h02;
                    n_pos = pos_adv;
                end
                CMD_WRDI: begin
                    if (r_pos == 2'd0) n_status = r_status & ~8'h02;
                    n_pos = pos_adv;
                end
                CMD_RDSR: begin
                    kind    = OUT_SET;
                    set_val = r_status;
                end
                CMD_WRSR: begin
                    if (r_pos == 2'd0 && r_status[1]) n_status = v & ST_KEEP_MASK;
                    n_pos = pos_adv;
                end
                CMD_READ, CMD_WRITE: begin
                    if (r_pos != 2'd3) begin
                        case (eff_pos)
                            2'd0:    n_address = {v[0], 16'b0};
                            2'd1:    n_address = addr_base | {1'b0, v, 8'b0};
                            default: n_address = addr_base | {{(ADDR_W-8){1'b0}}, v};
                        endcase
                        n_pos = eff_pos + 2'd1;
                    end else if (r_command == CMD_READ) begin
                        kind      = in_range ? OUT_MEM : OUT_SET;
                        set_val   = BYTE_FF;
                        n_address = addr_inc & cfg.address_mask;
                    end else begin
                        kind    = OUT_SET;
                        set_val = BYTE_FF;
                        if (!refused) begin
                            mem_we    = in_range;
                            n_dirty   = r_dirty | in_range;
                            n_address = (r_address & ~page17) | (addr_inc & page17);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // single-port array: write-back and read share the request's slot
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (mem_we) r_mem[r_address[MEM_AW-1:0]] <= v;
            r_rd_data <= r_mem[r_address[MEM_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_selected <= 1'b0;
            r_command  <= 8'd0;
            r_pos      <= 2'd0;
            r_address  <= '0;
            r_status   <= 8'd0;
            r_dirty    <= 1'b0;
        end else if (in_accept) begin
            r_selected <= n_selected;
            r_command  <= n_command;
            r_pos      <= n_pos;
            r_address  <= n_address;
            r_status   <= n_status;
            r_dirty    <= n_dirty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_kind  <= kind;
            r_s1_val   <= set_val;
            r_s1_dirty <= n_dirty;
        end
    end

    always_comb begin
        case (r_s1_kind)
            OUT_MEM: s1_byte = r_rd_data;
            OUT_SET: s1_byte = r_s1_val;
            default: s1_byte = r_out_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_byte <= 8'd0;
            r_o_valid  <= 1'b0;
        end else if (s1_move) begin
            r_out_byte <= s1_byte;
            r_o_valid  <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_data.read_byte   <= s1_byte;
            r_o_data.store_dirty <= r_s1_dirty;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule
`default_nettype wire

FILE: rtl/sce_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI EEPROM command engine checker
// Port-level properties of the command engine, bound to the top level.
// ----------------------------------------------------------------------------
module sce_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire sce_pkg::t_in                i_in_data,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire sce_pkg::t_out               o_out_data,
    input wire logic                        psel,
    input wire logic                        penable,
    input wire logic                        pwrite,
    input wire logic [sce_pkg::PADDR_W-1:0] paddr,
    input wire logic [31:0]                 pwdata,
    input wire logic [31:0]                 prdata,
    input wire logic                        pready
);
    import sce_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // every accepted request shows a result after the result stage and output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##2 o_out_valid)
        else $error("result missing after request");

    // input back-pressure only arises from a stalled output
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // dirty flag never clears once shown
    a_dirty_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_data.store_dirty
        |=> !o_out_valid || o_out_data.store_dirty)
        else $error("store dirty flag cleared");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable |-> pready)
        else $error("register access not ready");

endmodule

bind spi_eeprom_command_engine sce_checker u_sce_checker (.*);
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI EEPROM command engine testbench
// Streams SPI command sequences (status access, protected and open writes,
// sequential reads) through the engine under random idling on both sides and
// several register settings, and checks every shifted-out byte and the dirty
// flag against a built-in prediction of the device.
// ----------------------------------------------------------------------------
module tb;
    import sce_pkg::*;

    localparam int PLAN = 0;   // copy that runs ahead while requests are queued
    localparam int LIVE = 1;   // copy that advances on accepted requests

    localparam logic [1:0] PROTECT_NONE    = 2'd0;
    localparam logic [1:0] PROTECT_QUARTER = 2'd1;
    localparam logic [1:0] PROTECT_HALF    = 2'd2;
    localparam logic [1:0] PROTECT_ALL     = 2'd3;
    localparam int         ST_WEL          = 1;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 165;

    typedef logic [7:0] byte_seq_t [$];

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    t_in                req_data = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    t_out               rsp_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    spi_eeprom_command_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_data   (req_data),
        .o_out_valid (rsp_valid),
        .i_out_stall (rsp_stall),
        .o_out_data  (rsp_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 clk = ~clk;

    t_cfg cfg = '{RST_ADDRESS_BYTES, RST_ADDRESS_MASK, RST_PAGE_WRAP,
                  RST_HALF_START, RST_QUARTER_START};

    // device state, one copy per index
    bit                ee_selected [2];
    bit [7:0]          ee_command  [2];
    bit [1:0]          ee_pos      [2];
    bit [ADDR_W-1:0]   ee_addr     [2];
    bit [7:0]          ee_out      [2];
    bit [7:0]          ee_status   [2];
    bit                ee_dirty    [2];
    bit [7:0]          ee_mem      [2][MEM_BYTES];
    bit                ee_written  [MEM_BYTES];
    logic [ADDR_W-1:0] written_addrs [$];

    t_in  mosi_queue   [$];
    t_out miso_expected [$];
    int   planned_items = 0;
    int   mismatches = 0;

    int   send_gap = 0, send_run = 0;
    bit   send_quiet = 1'b0;
    int   recv_hold = 0, recv_run = 0;
    bit   recv_quiet = 1'b0;

    function automatic void step_position(input int c);
        if (ee_pos[c] != 2'd3)
            ee_pos[c] = ee_pos[c] + 2'd1;
    endfunction

    function automatic t_out eeprom_shift_byte(input int c, input t_in req);
        logic [7:0]        v;
        logic [1:0]        mode;
        logic [1:0]        n;
        logic [ADDR_W-1:0] pm;
        t_out              res;
        v = req.data_byte;
        if (!ee_selected[c]) begin
            ee_command[c] = v;
            ee_pos[c] = 2'd0;
        end else begin
            case (ee_command[c])
                CMD_WREN: begin
                    if (ee_pos[c] == 2'd0)
                        ee_status[c][ST_WEL] = 1'b1;
                    step_position(c);
                end
                CMD_WRDI: begin
                    if (ee_pos[c] == 2'd0)
                        ee_status[c][ST_WEL] = 1'b0;
                    step_position(c);
                end
                CMD_RDSR: ee_out[c] = ee_status[c];
                CMD_WRSR: begin
                    if (ee_pos[c] == 2'd0 && ee_status[c][ST_WEL])
                        ee_status[c] = v & ST_KEEP_MASK;
                    step_position(c);
                end
                CMD_READ, CMD_WRITE: begin
                    if (ee_pos[c] != 2'd3) begin
                        // first address byte: skip the unused leading positions
                        if (ee_pos[c] == 2'd0) begin
                            n = (cfg.address_bytes == 2'd0) ? 2'd1 : cfg.address_bytes;
                            ee_addr[c] = '0;
                            ee_pos[c] = 2'd3 - n;
                        end
                        case (ee_pos[c])
                            2'd0:    ee_addr[c] = {v[0], 16'h0000};
                            2'd1:    ee_addr[c][15:8] = v;
                            default: ee_addr[c][7:0] = v;
                        endcase
                        step_position(c);
                    end else if (ee_command[c] == CMD_READ) begin
                        // a 17-bit address always lands inside the full-size array
                        ee_out[c] = ee_mem[c][ee_addr[c]];
                        ee_addr[c] = (ee_addr[c] + 1'b1) & cfg.address_mask;
                        step_position(c);
                    end else begin
                        mode = ee_status[c][3:2];
                        ee_out[c] = BYTE_FF;
                        if (!(mode == PROTECT_ALL
                              || (mode == PROTECT_QUARTER && ee_addr[c] >= cfg.quarter_start)
                              || (mode == PROTECT_HALF && ee_addr[c] >= cfg.half_start))) begin
                            ee_mem[c][ee_addr[c]] = v;
                            ee_dirty[c] = 1'b1;
                            if (c == PLAN && !ee_written[ee_addr[c]]) begin
                                ee_written[ee_addr[c]] = 1'b1;
                                written_addrs.push_back(ee_addr[c]);
                            end
                            pm = ADDR_W'(cfg.page_wrap);
                            ee_addr[c] = (ee_addr[c] & ~pm) | ((ee_addr[c] + 1'b1) & pm);
                            step_position(c);
                        end
                    end
                end
                default: ;
            endcase
        end
        ee_selected[c] = req.keep_selected;
        res.read_byte = ee_out[c];
        res.store_dirty = ee_dirty[c];
        return res;
    endfunction

    // Queues one request; returns whether chip select is still held after it.
    function automatic bit send_byte(input logic [7:0] data, input bit keep);
        t_in req;
        req.data_byte = data;
        req.keep_selected = keep;
        if (!ee_selected[PLAN] || ee_command[PLAN] inside
                {CMD_WRSR, CMD_WRITE, CMD_READ, CMD_WRDI, CMD_RDSR, CMD_WREN})
            planned_items++;
        void'(eeprom_shift_byte(PLAN, req));
        // deselect rather than let the next byte read a location never stored
        if (ee_selected[PLAN] && ee_command[PLAN] == CMD_READ && ee_pos[PLAN] == 2'd3
                && !ee_written[ee_addr[PLAN]]) begin
            req.keep_selected = 1'b0;
            ee_selected[PLAN] = 1'b0;
        end
        mosi_queue.push_back(req);
        return ee_selected[PLAN];
    endfunction

    // Mostly a clean transfer; now and then cut short or left selected.
    function automatic void send_seq(input byte_seq_t seq);
        int cut;
        bit keep;
        bit held;
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, seq.size() - 1)
                                           : seq.size() - 1;
        for (int i = 0; i <= cut; i++) begin
            keep = (i == cut) ? ($urandom_range(0, 19) == 0) : 1'b1;
            held = send_byte(seq[i], keep);
            if (!held && i < cut)
                break;
        end
    endfunction

    function automatic void add_address(inout byte_seq_t seq, input logic [ADDR_W-1:0] a);
        int n;
        n = (cfg.address_bytes == 2'd0) ? 1 : int'(cfg.address_bytes);
        if (n == 3)
            seq.push_back({7'($urandom), a[16]});
        if (n >= 2)
            seq.push_back(a[15:8]);
        seq.push_back(a[7:0]);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        case ($urandom_range(0, 3))
            0:       return cfg.quarter_start + ADDR_W'($urandom_range(0, 4)) - ADDR_W'(2);
            1:       return cfg.half_start + ADDR_W'($urandom_range(0, 4)) - ADDR_W'(2);
            2:       return ADDR_W'($urandom_range(0, int'(cfg.address_mask)));
            default: return ADDR_W'($urandom);
        endcase
    endfunction

    function automatic void random_transaction();
        byte_seq_t  seq;
        byte_seq_t  wren;
        logic [7:0] v;
        int         pick;
        int         len;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            seq.push_back(CMD_WRITE);
            add_address(seq, pick_address());
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, int'(cfg.page_wrap) + 3)
                                              : $urandom_range(1, 6);
            repeat (len) seq.push_back(8'($urandom));
        end else if (pick < 58) begin
            seq.push_back(CMD_READ);
            if (written_addrs.size() != 0 && $urandom_range(0, 3) != 0)
                add_address(seq, written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
            else
                add_address(seq, pick_address());
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            repeat (len) seq.push_back(8'($urandom));
        end else if (pick < 66) begin
            seq.push_back(CMD_RDSR);
            repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom));
        end else if (pick < 74) begin
            if ($urandom_range(0, 3) != 0) begin
                wren.push_back(CMD_WREN);
                wren.push_back(8'($urandom));
                send_seq(wren);
            end
            v = 8'($urandom);
            v[3:2] = ($urandom_range(0, 2) != 0) ? PROTECT_NONE : 2'($urandom_range(1, 3));
            seq.push_back(CMD_WRSR);
            seq.push_back(v);
            repeat ($urandom_range(0, 2)) seq.push_back(8'($urandom));
        end else if (pick < 90) begin
            seq.push_back((pick < 84) ? CMD_WREN : CMD_WRDI);
            repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom));
        end else if (pick < 95) begin
            if ($urandom_range(0, 2) == 0)
                v = 8'h00;
            else
                do v = 8'($urandom); while (v inside {[CMD_WRSR:CMD_WREN]});
            seq.push_back(v);
            repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 6)) void'(send_byte(8'($urandom), 1'($urandom)));
        end
        if (seq.size() != 0)
            send_seq(seq);
    endfunction

    // Wait length for one request, with runs of back-to-back traffic.
    function automatic int idle_cycles(inout int run, inout bit quiet);
        if (run == 0) begin
            run = $urandom_range(10, 80);
            quiet = ($urandom_range(0, 2) == 0);
        end
        run--;
        if (quiet)
            return 0;
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 3);
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        $display("mismatch in %s: got %h, want %h", what, got, want);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_config(input t_cfg c);
        write_reg(REG_ADDRESS_BYTES, 32'(c.address_bytes));
        write_reg(REG_ADDRESS_MASK, 32'(c.address_mask));
        write_reg(REG_PAGE_WRAP, 32'(c.page_wrap));
        write_reg(REG_HALF_START, 32'(c.half_start));
        write_reg(REG_QUARTER_START, 32'(c.quarter_start));
        cfg = c;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (mosi_queue.size() != 0 || req_valid || miso_expected.size() != 0);
    endtask

    // request side
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            send_gap = 0;
        end else if (!req_valid || !req_stall) begin
            if (req_valid) begin
                miso_expected.push_back(eeprom_shift_byte(LIVE, req_data));
                send_gap = idle_cycles(send_run, send_quiet);
            end
            if (send_gap == 0 && mosi_queue.size() != 0) begin
                req_data  <= mosi_queue.pop_front();
                req_valid <= 1'b1;
            end else begin
                req_valid <= 1'b0;
                if (send_gap > 0)
                    send_gap--;
            end
        end
    end

    // result side
    always @(posedge clk) begin : result_check
        t_out want;
        if (!rst_n) begin
            rsp_stall <= 1'b0;
            recv_hold = 0;
        end else begin
            if (rsp_valid && !rsp_stall) begin
                if (miso_expected.size() == 0) begin
                    report_mismatch("result with nothing pending", rsp_data.read_byte, 8'h00);
                end else begin
                    want = miso_expected.pop_front();
                    if (rsp_data.read_byte !== want.read_byte)
                        report_mismatch("read_byte", rsp_data.read_byte, want.read_byte);
                    if (rsp_data.store_dirty !== want.store_dirty)
                        report_mismatch("store_dirty", 8'(rsp_data.store_dirty),
                                        8'(want.store_dirty));
                end
                recv_hold = idle_cycles(recv_run, recv_quiet);
            end
            if (recv_hold > 0) begin
                rsp_stall <= 1'b1;
                recv_hold--;
            end else begin
                rsp_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        t_cfg c;
        int   target;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // status read and unknown command before anything is stored
        void'(send_byte(CMD_RDSR, 1'b1));  void'(send_byte(8'h00, 1'b0));
        void'(send_byte(8'h00, 1'b1));     void'(send_byte(8'hFF, 1'b0));
        // status write refused while write enable is clear
        void'(send_byte(CMD_WRSR, 1'b1));  void'(send_byte(8'hFF, 1'b0));
        // enable, then protect everything; second status byte has no effect
        void'(send_byte(CMD_WREN, 1'b1));  void'(send_byte(8'h00, 1'b0));
        void'(send_byte(CMD_WRSR, 1'b1));  void'(send_byte(8'hFF, 1'b1));
        void'(send_byte(8'h00, 1'b0));
        void'(send_byte(CMD_WRITE, 1'b1)); void'(send_byte(8'h1F, 1'b1));
        void'(send_byte(8'hFF, 1'b1));     void'(send_byte(8'hA5, 1'b0));
        // lift protection, store across the page edge, read back
        void'(send_byte(CMD_WRSR, 1'b1));  void'(send_byte(8'h00, 1'b0));
        void'(send_byte(CMD_WRITE, 1'b1)); void'(send_byte(8'h1F, 1'b1));
        void'(send_byte(8'hFF, 1'b1));     void'(send_byte(8'hA5, 1'b1));
        void'(send_byte(8'h5A, 1'b0));
        void'(send_byte(CMD_READ, 1'b1));  void'(send_byte(8'h1F, 1'b1));
        void'(send_byte(8'hFF, 1'b1));     void'(send_byte(8'h00, 1'b0));

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_idle();
                case (ph)
                    1: c = '{2'd3, ADDR_W'(131071), 8'd255, ADDR_W'(65536), ADDR_W'(98304)};
                    2: c = '{2'd1, ADDR_W'(0), 8'd0, ADDR_W'(0), ADDR_W'(0)};
                    // zero address bytes acts as one
                    3: c = '{2'd0, ADDR_W'(255), 8'd15, ADDR_W'(128), ADDR_W'(192)};
                    default: begin
                        c.address_bytes = 2'($urandom_range(1, 3));
                        c.address_mask = ($urandom_range(0, 3) == 0)
                            ? ADDR_W'($urandom_range(0, 131071))
                            : ADDR_W'((1 << $urandom_range(8, 17)) - 1);
                        c.page_wrap = ($urandom_range(0, 3) == 0)
                            ? 8'($urandom)
                            : 8'((1 << $urandom_range(0, 8)) - 1);
                        c.half_start = ADDR_W'($urandom_range(0, 65536));
                        c.quarter_start = ADDR_W'($urandom_range(0, 98304));
                    end
                endcase
                apply_config(c);
            end
            target = planned_items + PHASE_ITEMS;
            while (planned_items < target)
                random_transaction();
        end

        wait_idle();
        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin : watchdog
        #3000000;
        $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
